>>> hw/rtl/atr_pkg.sv
// Shared widths, CORDIC arctangent table and pipeline sideband type for the
// accelerometer tilt pipeline. No dependencies.
package atr_pkg;

   localparam int IN_W         = 16;
   localparam int ARG_SHIFT    = 14;
   localparam int ARG_W        = 34;
   localparam int ANG_W        = 29;
   localparam int ANG_FRAC     = 12;
   localparam int RND_W        = ANG_W - ANG_FRAC;
   localparam int CORDIC_STEPS = 18;
   localparam int SQ_W         = 32;
   localparam int RAD_W        = SQ_W + 2 * ARG_SHIFT;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int ROLL_W       = 16;
   localparam int PITCH_W      = 15;
   localparam int ROLL_LIM     = 18000;
   localparam int PITCH_LIM    = 9000;
   localparam int HALF_TURN    = 18000 << ANG_FRAC;

   // atan(2^-i) in 1/4096 centidegree
   localparam int ATAN_TAB [CORDIC_STEPS] = '{
      18432000, 10881045, 5749245, 2918407, 1464867, 733147,
      366663, 183343, 91673, 45837, 22918, 11459,
      5730, 2865, 1432, 716, 358, 179
   };

   // carried alongside the square root
   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic [IN_W:0]          roll_a;
      logic signed [IN_W:0]   roll_b;
      logic                   roll_neg;
      logic                   roll_up;
      logic                   roll_zero;
      logic                   pitch_zero;
   } side_type;

endpackage

>>> hw/rtl/atr_sqrt_pipe.sv
// Pipelined floor integer square root, one root bit per stage, with a
// sideband that travels in step. Depends on atr_pkg.
module atr_sqrt_pipe #(
   parameter int RAD_W  = atr_pkg::RAD_W,
   parameter int SIDE_W = $bits(atr_pkg::side_type)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic                valid_ff [ROOT_W];
   logic [RAD_W-1:0]    rad_ff   [ROOT_W-1];
   logic [REM_W-1:0]    rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   logic [SIDE_W-1:0]   side_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic                valid_prev;
      logic [RAD_W-1:0]    rad_prev;
      logic [REM_W-1:0]    rem_prev;
      logic [ROOT_W-1:0]   root_prev;
      logic [SIDE_W-1:0]   side_prev;
      logic [REM_W+1:0]    cat;
      logic [REM_W+1:0]    trial;
      logic [REM_W+1:0]    diff;
      logic                take;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rad_prev   = in_rad;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // bring down the next bit pair, try (root << 2) | 1
      assign cat   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      assign trial = {2'b00, root_prev, 2'b01};
      assign take  = (cat >= trial);
      assign diff  = cat - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? diff[REM_W-1:0] : cat[REM_W-1:0];
            root_ff[k] <= {root_prev[ROOT_W-2:0], take};
            side_ff[k] <= side_prev;
         end
      end

      if (k < ROOT_W - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[k] <= {rad_prev[RAD_W-3:0], 2'b00};
            end
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

>>> hw/rtl/atr_cordic_pipe.sv
// Unrolled CORDIC vectoring pipeline, one iteration per stage; accumulates
// the angle from a start value. Depends on atr_pkg (widths, arctangent table).
module atr_cordic_pipe #(
   parameter int STEPS  = atr_pkg::CORDIC_STEPS,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [atr_pkg::ARG_W-1:0]  in_a,
   input  logic signed [atr_pkg::ARG_W-1:0]  in_b,
   input  logic signed [atr_pkg::ANG_W-1:0]  in_ang,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic signed [atr_pkg::ANG_W-1:0]  out_ang,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int ARG_W = atr_pkg::ARG_W;
   localparam int ANG_W = atr_pkg::ANG_W;

   logic                     valid_ff [STEPS];
   logic signed [ARG_W-1:0]  a_ff     [STEPS-1];
   logic signed [ARG_W-1:0]  b_ff     [STEPS-1];
   logic signed [ANG_W-1:0]  ang_ff   [STEPS];
   logic [SIDE_W-1:0]        side_ff  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      logic                     valid_prev;
      logic signed [ARG_W-1:0]  a_prev;
      logic signed [ARG_W-1:0]  b_prev;
      logic signed [ANG_W-1:0]  ang_prev;
      logic [SIDE_W-1:0]        side_prev;
      logic signed [ANG_W-1:0]  step_ang;
      logic                     b_neg;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign a_prev     = in_a;
         assign b_prev     = in_b;
         assign ang_prev   = in_ang;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign a_prev     = a_ff[i-1];
         assign b_prev     = b_ff[i-1];
         assign ang_prev   = ang_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      assign step_ang = ANG_W'(atr_pkg::ATAN_TAB[i]);
      assign b_neg    = b_prev[ARG_W-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ang_ff[i]  <= b_neg ? ang_prev - step_ang : ang_prev + step_ang;
            side_ff[i] <= side_prev;
         end
      end

      // last iteration only needs the angle
      if (i < STEPS - 1) begin : g_vec
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[i] <= b_neg ? a_prev - (b_prev >>> i) : a_prev + (b_prev >>> i);
               b_ff[i] <= b_neg ? b_prev + (a_prev >>> i) : b_prev - (a_prev >>> i);
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_ang   = ang_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

>>> hw/rtl/accel_tilt_roll_pitch.sv
// Top level: roll and pitch in centidegrees from one accelerometer sample.
// Depends on atr_pkg, atr_sqrt_pipe and atr_cordic_pipe.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_accel_x, req_accel_y, req_accel_z
//   rsp     | out       | rsp_valid/rsp_stall | rsp_roll_angle, rsp_pitch_angle
//
// One sample per cycle unless rsp_stall holds a result. Input register, squares,
// sum, 30 square-root stages (one root bit each), 18 CORDIC stages, round register.
// Synchronous reset clears only the valid bits.
// A held result under rsp_stall freezes the whole pipeline; req_stall follows.
module accel_tilt_roll_pitch (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [atr_pkg::IN_W-1:0]     req_accel_x,
   input  logic signed [atr_pkg::IN_W-1:0]     req_accel_y,
   input  logic signed [atr_pkg::IN_W-1:0]     req_accel_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [atr_pkg::ROLL_W-1:0]   rsp_roll_angle,
   output logic signed [atr_pkg::PITCH_W-1:0]  rsp_pitch_angle
);

   localparam int IN_W      = atr_pkg::IN_W;
   localparam int ARG_W     = atr_pkg::ARG_W;
   localparam int ANG_W     = atr_pkg::ANG_W;
   localparam int RND_W     = atr_pkg::RND_W;
   localparam int SQ_W      = atr_pkg::SQ_W;
   localparam int RAD_W     = atr_pkg::RAD_W;
   localparam int ROOT_W    = atr_pkg::ROOT_W;
   localparam int ARG_SHIFT = atr_pkg::ARG_SHIFT;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: input register
   logic                    s1_valid_ff;
   logic signed [IN_W-1:0]  s1_x_ff, s1_y_ff, s1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff <= req_accel_x;
         s1_y_ff <= req_accel_y;
         s1_z_ff <= req_accel_z;
      end
   end

   // stage 2: squares and roll quadrant fold
   logic signed [2*IN_W-1:0] yy, zz;
   logic signed [IN_W:0]     y_ext, z_ext, neg_y;
   atr_pkg::side_type        s2_side_in;

   assign yy    = s1_y_ff * s1_y_ff;
   assign zz    = s1_z_ff * s1_z_ff;
   assign y_ext = (IN_W+1)'(s1_y_ff);
   assign z_ext = (IN_W+1)'(s1_z_ff);
   assign neg_y = -y_ext;

   always_comb begin
      s2_side_in.x          = s1_x_ff;
      s2_side_in.roll_neg   = s1_z_ff[IN_W-1];
      s2_side_in.roll_up    = !neg_y[IN_W];
      s2_side_in.roll_a     = s1_z_ff[IN_W-1] ? -z_ext : z_ext;
      s2_side_in.roll_b     = s1_z_ff[IN_W-1] ? y_ext : neg_y;
      s2_side_in.roll_zero  = (s1_y_ff == '0) && (s1_z_ff == '0);
      s2_side_in.pitch_zero = (s1_x_ff == '0) && (s1_y_ff == '0) && (s1_z_ff == '0);
   end

   logic                    s2_valid_ff;
   logic [SQ_W-2:0]         s2_yy_ff, s2_zz_ff;
   atr_pkg::side_type       s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_yy_ff   <= yy[SQ_W-2:0];
         s2_zz_ff   <= zz[SQ_W-2:0];
         s2_side_ff <= s2_side_in;
      end
   end

   // stage 3: sum of squares
   logic                    s3_valid_ff;
   logic [SQ_W-1:0]         s3_sq_ff;
   atr_pkg::side_type       s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sq_ff   <= SQ_W'(s2_yy_ff) + SQ_W'(s2_zz_ff);
         s3_side_ff <= s2_side_ff;
      end
   end

   // hypot(y, z) * 2^14
   logic                    sq_valid;
   logic [ROOT_W-1:0]       sq_root;
   atr_pkg::side_type       sq_side;
   logic [RAD_W-1:0]        sq_rad;

   assign sq_rad = {s3_sq_ff, (2*ARG_SHIFT)'(0)};

   atr_sqrt_pipe #(
      .RAD_W  (RAD_W),
      .SIDE_W ($bits(atr_pkg::side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_rad    (sq_rad),
      .in_side   (s3_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // CORDIC arguments
   logic signed [ARG_W-1:0] roll_a, roll_b, pitch_a, pitch_b;
   logic signed [ANG_W-1:0] roll_base;

   assign roll_a  = signed'(ARG_W'(sq_side.roll_a)) <<< ARG_SHIFT;
   assign roll_b  = signed'(ARG_W'(sq_side.roll_b)) <<< ARG_SHIFT;
   assign pitch_a = signed'(ARG_W'(sq_root));
   assign pitch_b = signed'(ARG_W'(sq_side.x)) <<< ARG_SHIFT;

   always_comb begin
      if (!sq_side.roll_neg) begin
         roll_base = '0;
      end else if (sq_side.roll_up) begin
         roll_base = ANG_W'(atr_pkg::HALF_TURN);
      end else begin
         roll_base = -ANG_W'(atr_pkg::HALF_TURN);
      end
   end

   logic                    roll_valid, pitch_valid;
   logic signed [ANG_W-1:0] roll_ang, pitch_ang;
   logic                    roll_zero, pitch_zero;

   atr_cordic_pipe #(
      .STEPS  (atr_pkg::CORDIC_STEPS),
      .SIDE_W (1)
   ) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_a      (roll_a),
      .in_b      (roll_b),
      .in_ang    (roll_base),
      .in_side   (sq_side.roll_zero),
      .out_valid (roll_valid),
      .out_ang   (roll_ang),
      .out_side  (roll_zero)
   );

   atr_cordic_pipe #(
      .STEPS  (atr_pkg::CORDIC_STEPS),
      .SIDE_W (1)
   ) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_a      (pitch_a),
      .in_b      (pitch_b),
      .in_ang    ('0),
      .in_side   (sq_side.pitch_zero),
      .out_valid (pitch_valid),
      .out_ang   (pitch_ang),
      .out_side  (pitch_zero)
   );

   // round half up to centidegrees, clamp
   logic signed [ANG_W-1:0] roll_sum, pitch_sum;
   logic signed [RND_W-1:0] roll_r, pitch_r, roll_c, pitch_c;

   assign roll_sum  = roll_ang + ANG_W'(1 << (atr_pkg::ANG_FRAC - 1));
   assign pitch_sum = pitch_ang + ANG_W'(1 << (atr_pkg::ANG_FRAC - 1));
   assign roll_r    = roll_sum[ANG_W-1:atr_pkg::ANG_FRAC];
   assign pitch_r   = pitch_sum[ANG_W-1:atr_pkg::ANG_FRAC];

   always_comb begin
      if (roll_r > RND_W'(atr_pkg::ROLL_LIM)) begin
         roll_c = RND_W'(atr_pkg::ROLL_LIM);
      end else if (roll_r < -RND_W'(atr_pkg::ROLL_LIM)) begin
         roll_c = -RND_W'(atr_pkg::ROLL_LIM);
      end else begin
         roll_c = roll_r;
      end
      if (pitch_r > RND_W'(atr_pkg::PITCH_LIM)) begin
         pitch_c = RND_W'(atr_pkg::PITCH_LIM);
      end else if (pitch_r < -RND_W'(atr_pkg::PITCH_LIM)) begin
         pitch_c = -RND_W'(atr_pkg::PITCH_LIM);
      end else begin
         pitch_c = pitch_r;
      end
   end

   // output register
   logic                                  rsp_valid_ff;
   logic signed [atr_pkg::ROLL_W-1:0]     rsp_roll_ff;
   logic signed [atr_pkg::PITCH_W-1:0]    rsp_pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= roll_valid && pitch_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_roll_ff  <= roll_zero  ? '0 : roll_c[atr_pkg::ROLL_W-1:0];
         rsp_pitch_ff <= pitch_zero ? '0 : pitch_c[atr_pkg::PITCH_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;

endmodule
